/* hw/rtl/rcpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC pulse capture package
// Shared widths, port count, event codes and register indexes.
// ----------------------------------------------------------------------------
package rcpc_pkg;

  localparam int NUM_PORTS  = 8;
  localparam int PORT_W     = 3;
  localparam int STAMP_W    = 16;
  localparam int WIDTH_W    = 32;
  localparam int MASK_W     = 8;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  typedef enum logic {
    OP_CAPTURE  = 1'b0,
    OP_OVERFLOW = 1'b1
  } op_t;

  typedef enum logic {
    REG_PORT_ENABLE = 1'b0,
    REG_PPM_MODE    = 1'b1
  } reg_idx_t;

endpackage

/* hw/rtl/rcpc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC pulse capture channels
// Timer event channel and measurement result channel, valid/ready.
// ----------------------------------------------------------------------------
interface rcpc_evt_if;
  import rcpc_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic [PORT_W-1:0]  port;
  logic [STAMP_W-1:0] capture;
  logic               pin_level;

  modport source (output valid, operation, port, capture, pin_level, input ready);
  modport sink   (input valid, operation, port, capture, pin_level, output ready);
endinterface

interface rcpc_meas_if;
  import rcpc_pkg::*;

  logic               valid;
  logic               ready;
  logic [PORT_W-1:0]  result_port;
  logic [WIDTH_W-1:0] pulse_width;

  modport source (output valid, result_port, pulse_width, input ready);
  modport sink   (input valid, result_port, pulse_width, output ready);
endinterface

/* hw/rtl/rc_pwm_ppm_pulse_capture.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC PWM/PPM pulse capture
// Per-port pulse measurement from timer capture and overflow events.
// ----------------------------------------------------------------------------
// Takes one timer event per cycle unless a measurement is held back by meas.ready,
// and gives at most one measurement per event, via the event then result register.
// A PWM port stores the timestamp of a high edge and reports the 16-bit
// wrapped high width on the next low edge. A PPM port sums overflow periods
// into a 32-bit accumulator and reports the 32-bit wrapped time between
// successive edges. Events on ports that are not enabled are dropped; overflow
// events on PWM ports are dropped. Per-port state is read and updated in the
// result stage, so back-to-back events on the same port need no forwarding.
// Registers: 0x0 port enable mask, 0x4 PPM mode mask (8 bits each).
// ----------------------------------------------------------------------------
module rc_pwm_ppm_pulse_capture (
  input  logic                             clk,
  input  logic                             rst,
  rcpc_evt_if.sink                         evt,
  rcpc_meas_if.source                      meas,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rcpc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [rcpc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [rcpc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import rcpc_pkg::*;

  // configuration
  logic [MASK_W-1:0] port_enable_mask;
  logic [MASK_W-1:0] ppm_mode_mask;
  reg_idx_t          reg_sel;
  logic              cfg_write;

  // event register
  logic               ev_valid;
  op_t                ev_op;
  logic [PORT_W-1:0]  ev_port;
  logic [STAMP_W-1:0] ev_capture;
  logic               ev_pin_level;

  // per-port state
  logic [WIDTH_W-1:0] last_edge_time [NUM_PORTS];
  logic [WIDTH_W-1:0] overflow_total [NUM_PORTS];

  // result register
  logic               res_valid;
  logic [PORT_W-1:0]  res_port;
  logic [WIDTH_W-1:0] res_width;

  // result stage logic
  logic               port_open;
  logic               is_ppm;
  logic [WIDTH_W-1:0] last_sel;
  logic [WIDTH_W-1:0] ovf_sel;
  logic [WIDTH_W-1:0] now_time;
  logic [WIDTH_W-1:0] ppm_width;
  logic [STAMP_W-1:0] pwm_width;
  logic               emit;
  logic               res_free;
  logic               ev_advance;
  logic               do_ovf;
  logic               do_last;
  logic [WIDTH_W-1:0] last_next;
  logic [WIDTH_W-1:0] width_next;

  assign pready    = 1'b1;
  assign reg_sel   = reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      REG_PORT_ENABLE: prdata = {{(APB_DATA_W-MASK_W){1'b0}}, port_enable_mask};
      REG_PPM_MODE:    prdata = {{(APB_DATA_W-MASK_W){1'b0}}, ppm_mode_mask};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_enable_mask <= '0;
      ppm_mode_mask    <= '0;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_PORT_ENABLE: port_enable_mask <= pwdata[MASK_W-1:0];
        REG_PPM_MODE:    ppm_mode_mask    <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // result stage
  assign port_open = port_enable_mask[ev_port];
  assign is_ppm    = ppm_mode_mask[ev_port];
  assign last_sel  = last_edge_time[ev_port];
  assign ovf_sel   = overflow_total[ev_port];
  assign now_time  = ovf_sel + {{(WIDTH_W-STAMP_W){1'b0}}, ev_capture};
  assign ppm_width = now_time - last_sel;
  assign pwm_width = ev_capture - last_sel[STAMP_W-1:0];

  always_comb begin
    emit       = 1'b0;
    do_ovf     = 1'b0;
    do_last    = 1'b0;
    last_next  = now_time;
    width_next = ppm_width;
    if (ev_valid && port_open) begin
      if (ev_op == OP_OVERFLOW) begin
        do_ovf = is_ppm;
      end else if (is_ppm) begin
        emit    = 1'b1;
        do_last = 1'b1;
      end else if (ev_pin_level) begin
        do_last   = 1'b1;
        last_next = {{(WIDTH_W-STAMP_W){1'b0}}, ev_capture};
      end else begin
        emit       = 1'b1;
        width_next = {{(WIDTH_W-STAMP_W){1'b0}}, pwm_width};
      end
    end
  end

  assign res_free   = !res_valid || meas.ready;
  assign ev_advance = ev_valid && (!emit || res_free);
  assign evt.ready  = !ev_valid || ev_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (evt.ready) begin
      ev_valid <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.ready && evt.valid) begin
      ev_op        <= op_t'(evt.operation);
      ev_port      <= evt.port;
      ev_capture   <= evt.capture;
      ev_pin_level <= evt.pin_level;
    end
  end

  // update per-port state only when the event leaves the event register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        last_edge_time[i] <= '0;
        overflow_total[i] <= '0;
      end
    end else if (ev_advance) begin
      if (do_ovf) begin
        overflow_total[ev_port] <= now_time;
      end
      if (do_last) begin
        last_edge_time[ev_port] <= last_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= ev_advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_advance && emit) begin
      res_port  <= ev_port;
      res_width <= width_next;
    end
  end

  assign meas.valid       = res_valid;
  assign meas.result_port = res_port;
  assign meas.pulse_width = res_width;

endmodule
